/* rtl/kdop_pkg.sv */
// ----------------------------------------------------------------------------
// kdop_pkg: shared types and helpers for the k-DOP hull tracker
// Word layouts of both channels, the link word between cells, and the
// elaboration-time helpers that give each cell its normal and scale factor.
// ----------------------------------------------------------------------------
package kdop_pkg;

	localparam int COORD_W = 16;
	localparam int DIST_W  = 25;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam int RECIP_W = 17;
	localparam int TOL_W   = 8;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	// Register index decoded from paddr[2].
	localparam logic REG_TOLERANCE = 1'b0;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                       command;
		logic                       start_new;
		logic signed [COORD_W-1:0]  x_coord;
		logic signed [COORD_W-1:0]  y_coord;
		logic signed [COORD_W-1:0]  z_coord;
	} point_t;

	typedef struct packed {
		logic              inside_res;
		logic [DIST_W-1:0] distance;
		logic              hull_empty;
	} result_t;

	// Word handed from one cell to the next.
	typedef struct packed {
		logic                       valid;
		logic                       query;
		logic                       fresh;
		logic                       in_hull;
		logic                       empty;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [COORD_W-1:0]  z;
		logic [DIST_W-1:0]          best;
		logic [DIST_W-1:0]          cand;
	} hop_t;

	typedef struct packed {
		logic signed [2:0] a;
		logic signed [2:0] b;
		logic signed [2:0] c;
	} nrm_t;

	function automatic int num_normals(int g);
		return ((2 * g + 1) ** 3 - (2 * g - 1) ** 3) / 2;
	endfunction

	// The k-th lexicographically positive lattice direction on the cube shell.
	function automatic nrm_t normal_at(int g, int k);
		nrm_t n;
		int   cnt;
		bit   pos;
		bit   shell;
		n = '0;
		cnt = 0;
		for (int a = 0; a <= g; a++) begin
			for (int b = -g; b <= g; b++) begin
				for (int c = -g; c <= g; c++) begin
					pos = (a > 0) || (a == 0 && b > 0) || (a == 0 && b == 0 && c > 0);
					shell = (a == g) || (b == g) || (b == -g) || (c == g) || (c == -g);
					if (pos && shell) begin
						if (cnt == k) begin
							n.a = 3'(a);
							n.b = 3'(b);
							n.c = 3'(c);
						end
						cnt++;
					end
				end
			end
		end
		return n;
	endfunction

	// Largest r with s*(2r-1)^2 <= 2^34, i.e. round(65536/sqrt(s)).
	function automatic longint recip_norm(longint s);
		longint lo;
		longint hi;
		longint mid;
		longint t;
		lo = 1;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			t = 2 * mid - 1;
			if (s * t * t <= (64'sd1 <<< 34))
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

endpackage

/* rtl/kdop_hull_tracker.sv */
// ----------------------------------------------------------------------------
// kdop_hull_tracker: k-DOP bounding volume of a 3D point stream
// A row of cells, one per normal, keeps the slab bounds; each word walks the
// row and a query leaves it with its inside flag and, when inside, its least plane distance.
//
//   channel   handshake                 payload
//   point     point_valid/point_stall   point  (command, start_new, x, y, z)
//   result    result_valid/result_stall result (inside_res, distance, hull_empty)
//   config    APB psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// One word enters per cycle while the row is not stopped. A query's result
// word is presented once it has passed two register stages per cell: the edge
// that took it loads the first of these, and the output register follows the
// last cell. Adds produce no result. Reset clears the row's valid bits, the
// hull flag and the tolerance; the bounds are written by the first add.
// The row stops only when a query reaches its end while a result is stalled.
// ----------------------------------------------------------------------------
module kdop_hull_tracker #(
	parameter int GRANULARITY = 2,
	parameter int COORD_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            point_valid,
	output logic                            point_stall,
	input  kdop_pkg::point_t                point,
	output logic                            result_valid,
	input  logic                            result_stall,
	output kdop_pkg::result_t               result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [kdop_pkg::ADDR_W-1:0]     paddr,
	input  logic [kdop_pkg::DATA_W-1:0]     pwdata,
	output logic [kdop_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);

	localparam int NUM_NORMALS = kdop_pkg::num_normals(GRANULARITY);
	localparam int IN_BITS = (COORD_BITS < kdop_pkg::COORD_W) ? COORD_BITS
		: kdop_pkg::COORD_W;
	localparam int PROJ_W = IN_BITS + $clog2(3 * GRANULARITY) + 1;

	logic [kdop_pkg::TOL_W-1:0] tol_q;
	logic                       hull_valid_q;
	logic                       en;
	logic                       take;
	logic                       tail_query;
	logic signed [IN_BITS-1:0]  x_in;
	logic signed [IN_BITS-1:0]  y_in;
	logic signed [IN_BITS-1:0]  z_in;
	logic [kdop_pkg::DIST_W-1:0] tail_best;
	kdop_pkg::hop_t             link [0:NUM_NORMALS];
	kdop_pkg::result_t          result_q;
	logic                       result_valid_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == kdop_pkg::REG_TOLERANCE)
		? kdop_pkg::DATA_W'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == kdop_pkg::REG_TOLERANCE) begin
			tol_q <= pwdata[kdop_pkg::TOL_W-1:0];
		end
	end

	assign tail_query = link[NUM_NORMALS].valid
		&& link[NUM_NORMALS].query == kdop_pkg::CMD_QUERY;
	assign en = !(result_valid_q && result_stall && tail_query);
	assign point_stall = !en;
	assign take = point_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hull_valid_q <= 1'b0;
		end else if (take && point.command == kdop_pkg::CMD_ADD) begin
			hull_valid_q <= 1'b1;
		end
	end

	always_comb begin
		x_in = point.x_coord[IN_BITS-1:0];
		y_in = point.y_coord[IN_BITS-1:0];
		z_in = point.z_coord[IN_BITS-1:0];
		link[0].valid = take;
		link[0].query = point.command;
		// An add to an empty hull seeds it just as a start does.
		link[0].fresh = point.start_new || !hull_valid_q;
		link[0].in_hull = hull_valid_q;
		link[0].empty = !hull_valid_q;
		link[0].x = kdop_pkg::COORD_W'(x_in);
		link[0].y = kdop_pkg::COORD_W'(y_in);
		link[0].z = kdop_pkg::COORD_W'(z_in);
		link[0].best = kdop_pkg::DIST_MAX;
		link[0].cand = kdop_pkg::DIST_MAX;
	end

	for (genvar k = 0; k < NUM_NORMALS; k++) begin : g_cell
		kdop_cell #(
			.GRANULARITY (GRANULARITY),
			.INDEX       (k),
			.PROJ_W      (PROJ_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.tol    (tol_q),
			.prev   (link[k]),
			.next   (link[k+1])
		);
	end

	assign tail_best = (link[NUM_NORMALS].cand < link[NUM_NORMALS].best)
		? link[NUM_NORMALS].cand : link[NUM_NORMALS].best;

	always_ff @(posedge clk) begin
		if (en && tail_query) begin
			result_q.inside_res <= link[NUM_NORMALS].in_hull;
			result_q.distance <= link[NUM_NORMALS].in_hull ? tail_best : kdop_pkg::DIST_MAX;
			result_q.hull_empty <= link[NUM_NORMALS].empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en && tail_query) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

/* rtl/kdop_cell.sv */
// ----------------------------------------------------------------------------
// kdop_cell: one normal of the hull
// Holds the least and greatest projection for its normal, folds in added
// points, tests queried points against its slab and scales the nearer
// plane distance. Two register stages from input word to output word.
// ----------------------------------------------------------------------------
module kdop_cell #(
	parameter int GRANULARITY = 2,
	parameter int INDEX       = 0,
	parameter int PROJ_W      = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [kdop_pkg::TOL_W-1:0]    tol,
	input  kdop_pkg::hop_t                prev,
	output kdop_pkg::hop_t                next
);

	localparam kdop_pkg::nrm_t NRM = kdop_pkg::normal_at(GRANULARITY, INDEX);
	localparam int SQ = NRM.a * NRM.a + NRM.b * NRM.b + NRM.c * NRM.c;
	localparam logic [kdop_pkg::RECIP_W-1:0] RECIP =
		kdop_pkg::RECIP_W'(kdop_pkg::recip_norm(longint'(SQ)));
	localparam logic signed [PROJ_W-1:0] CA = PROJ_W'(NRM.a);
	localparam logic signed [PROJ_W-1:0] CB = PROJ_W'(NRM.b);
	localparam logic signed [PROJ_W-1:0] CC = PROJ_W'(NRM.c);
	localparam int TW = PROJ_W + 2;
	localparam int DW = PROJ_W + 1;
	localparam int PW = PROJ_W + kdop_pkg::RECIP_W + 1;
	localparam int SHW = PW - 8;
	localparam int SW = (SHW > kdop_pkg::DIST_W) ? SHW : kdop_pkg::DIST_W;

	logic signed [PROJ_W-1:0] min_q;
	logic signed [PROJ_W-1:0] max_q;

	logic signed [PROJ_W-1:0] p;
	logic signed [TW-1:0]     p_t;
	logic signed [TW-1:0]     lo_t;
	logic signed [TW-1:0]     hi_t;
	logic signed [TW-1:0]     tol_t;
	logic                     in_slab;
	logic signed [DW-1:0]     diff_lo;
	logic signed [DW-1:0]     diff_hi;
	logic signed [DW-1:0]     mag_lo;
	logic signed [DW-1:0]     mag_hi;
	logic [PROJ_W-1:0]        d_lo;
	logic [PROJ_W-1:0]        d_hi;
	logic [kdop_pkg::DIST_W-1:0] best_a;
	kdop_pkg::hop_t           hop_a;
	kdop_pkg::hop_t           hop_b;

	kdop_pkg::hop_t     hop_s1;
	logic               v_s1;
	logic [PROJ_W-1:0]  dmin_s1;
	kdop_pkg::hop_t     hop_s2;
	logic               v_s2;

	logic [PW-1:0]  prod;
	logic [SHW-1:0] prod_sh;
	logic [SW-1:0]  prod_ext;
	logic [kdop_pkg::DIST_W-1:0] cand;

	always_comb begin
		p = CA * PROJ_W'(prev.x) + CB * PROJ_W'(prev.y) + CC * PROJ_W'(prev.z);
		p_t = TW'(p);
		tol_t = TW'($signed({1'b0, tol}));
		lo_t = TW'(min_q) - tol_t;
		hi_t = TW'(max_q) + tol_t;
		in_slab = (p_t >= lo_t) && (p_t <= hi_t);
		diff_lo = DW'(p) - DW'(min_q);
		diff_hi = DW'(p) - DW'(max_q);
		mag_lo = (diff_lo < 0) ? -diff_lo : diff_lo;
		mag_hi = (diff_hi < 0) ? -diff_hi : diff_hi;
		d_lo = mag_lo[PROJ_W-1:0];
		d_hi = mag_hi[PROJ_W-1:0];
		// The candidate handed in by the previous cell is folded in here.
		best_a = (prev.cand < prev.best) ? prev.cand : prev.best;
		hop_a = prev;
		hop_a.best = best_a;
		hop_a.in_hull = prev.in_hull & in_slab;
	end

	// Bounds and first stage.
	always_ff @(posedge clk) begin
		if (en) begin
			if (prev.valid && prev.query == kdop_pkg::CMD_ADD) begin
				if (prev.fresh || p < min_q)
					min_q <= p;
				if (prev.fresh || p > max_q)
					max_q <= p;
			end
			hop_s1 <= hop_a;
			// The scaled distance grows with d, so only the nearer plane matters.
			dmin_s1 <= (d_lo < d_hi) ? d_lo : d_hi;
		end
	end

	always_comb begin
		prod = PW'(dmin_s1) * PW'(RECIP) + PW'(128);
		prod_sh = prod[PW-1:8];
		prod_ext = SW'(prod_sh);
		cand = (prod_ext > SW'(kdop_pkg::DIST_MAX)) ? kdop_pkg::DIST_MAX
			: kdop_pkg::DIST_W'(prod_ext);
		hop_b = hop_s1;
		hop_b.cand = cand;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hop_s2 <= hop_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= prev.valid;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		next = hop_s2;
		next.valid = v_s2;
	end

endmodule
